### hdl/sskio_pkg.sv
package sskio_pkg;

   // command codes of the request channel
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_KEY   = 2'd2
   } cmd_type;

   // csr register indexes
   localparam logic [1:0] CSR_CTRL_KEY  = 2'd0;
   localparam logic [1:0] CSR_BREAK_KEY = 2'd1;
   localparam logic [1:0] CSR_ENTER_KEY = 2'd2;

   localparam logic [15:0] CTRL_KEY_RESET  = 16'd256;
   localparam logic [15:0] BREAK_KEY_RESET = 16'd257;
   localparam logic [15:0] ENTER_KEY_RESET = 16'd258;

   // i/o page addresses
   localparam logic [7:0] ADDR_LATCH_LAST  = 8'h0F;
   localparam logic [7:0] ADDR_STROBE      = 8'h10;
   localparam logic [7:0] ADDR_GR_STATUS   = 8'h1A;
   localparam logic [7:0] ADDR_MIX_STATUS  = 8'h1B;
   localparam logic [7:0] ADDR_PAGE_STATUS = 8'h1C;
   localparam logic [7:0] ADDR_HIRES_STATUS = 8'h1D;
   localparam logic [7:0] ADDR_GR_SET      = 8'h50;
   localparam logic [7:0] ADDR_GR_CLR      = 8'h51;
   localparam logic [7:0] ADDR_MIX_CLR     = 8'h52;
   localparam logic [7:0] ADDR_MIX_SET     = 8'h53;
   localparam logic [7:0] ADDR_PAGE_ONE    = 8'h54;
   localparam logic [7:0] ADDR_PAGE_TWO    = 8'h55;
   localparam logic [7:0] ADDR_HIRES_CLR   = 8'h56;
   localparam logic [7:0] ADDR_HIRES_SET   = 8'h57;

   localparam logic [7:0] STATUS_ON = 8'h80;

   // key translation
   localparam logic [15:0] STROBE_BIT    = 16'h0080;
   localparam logic [15:0] STROBE_CLR    = 16'hFF7F;
   localparam logic [15:0] UPPER_MASK    = 16'hFFDF;
   localparam logic [15:0] KEY_LOWER_A   = 16'h0061;
   localparam logic [15:0] KEY_LOWER_Z   = 16'h007A;
   localparam logic [15:0] KEY_UPPER_A   = 16'h0041;
   localparam logic [15:0] KEY_UPPER_Z   = 16'h005A;
   localparam logic [15:0] CTRL_OFFSET   = 16'h0040;
   localparam logic [15:0] KEY_CTRL_C    = 16'h0003;
   localparam logic [15:0] KEY_RETURN    = 16'h000D;
   localparam logic [15:0] KEY_RELEASED  = 16'h0000;

   // video windows
   localparam logic [15:0] TEXT1_BEGIN  = 16'h0400;
   localparam logic [15:0] TEXT1_END    = 16'h0800;
   localparam logic [15:0] TEXT2_BEGIN  = 16'h0800;
   localparam logic [15:0] TEXT2_END    = 16'h0C00;
   localparam logic [15:0] HIRES1_BEGIN = 16'h2000;
   localparam logic [15:0] HIRES1_END   = 16'h4000;
   localparam logic [15:0] HIRES2_BEGIN = 16'h4000;
   localparam logic [15:0] HIRES2_END   = 16'h6000;
   localparam logic [15:0] MIXED2_END   = 16'h6000;
   localparam logic [15:0] MIXED1_END   = 16'h4000;

   typedef struct packed {
      logic [7:0]  read_data;
      logic        graphic_on;
      logic        hires_on;
      logic        mixed_on;
      logic        page_two;
      logic [15:0] window_begin;
      logic [15:0] window_end;
      logic [15:0] translated_key;
   } rsp_type;

endpackage

### hdl/soft_switch_keyboard_io_top.sv
// soft switch and keyboard block of an emulated i/o page. every request beat
// (bus read, bus write or host key event) yields exactly one response beat
// in the cycle after it is taken, and a new request can be taken every cycle:
// the mode flags, the keyboard latch and the control toggle are updated by a
// single level of decode logic, and the response sits in one output register
// that is reloaded in the same cycle it is drained, so throughput is one beat
// per clock for as long as the response side does not stall. req_stall is
// high only while a response waits and rsp_stall is high. key codes for
// control, break and enter are set through the csr port, which is always
// ready and should be written only while no request is in flight.
module soft_switch_keyboard_io_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_io_addr,
   input  logic [15:0] req_key_code,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_graphic_on,
   output logic        rsp_hires_on,
   output logic        rsp_mixed_on,
   output logic        rsp_page_two,
   output logic [15:0] rsp_window_begin,
   output logic [15:0] rsp_window_end,
   output logic [15:0] rsp_translated_key,
   // csr write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   // key code registers
   logic [15:0] ctrl_code_ff, break_code_ff, enter_code_ff;

   // block state
   logic        graphic_ff, graphic_in;
   logic        hires_ff, hires_in;
   logic        mixed_ff, mixed_in;
   logic        page_ff, page_in;
   logic        ctrl_ff, ctrl_in;
   logic [15:0] latch_ff, latch_in;
   logic [15:0] last_key_ff, last_key_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   sskio_pkg::rsp_type   rsp_ff, rsp_in;

   logic                 req_take;
   sskio_pkg::cmd_type   cmd;
   logic                 sw_hit;
   logic [7:0]           rd;
   logic [15:0]          key;

   assign csr_ready = 1'b1;

   // a waiting response blocks only while the far side stalls
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign cmd       = sskio_pkg::cmd_type'(req_cmd);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_code_ff  <= sskio_pkg::CTRL_KEY_RESET;
         break_code_ff <= sskio_pkg::BREAK_KEY_RESET;
         enter_code_ff <= sskio_pkg::ENTER_KEY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            sskio_pkg::CSR_CTRL_KEY:  ctrl_code_ff  <= csr_data;
            sskio_pkg::CSR_BREAK_KEY: break_code_ff <= csr_data;
            sskio_pkg::CSR_ENTER_KEY: enter_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // next state and response for the beat at the input
   always_comb begin
      graphic_in  = graphic_ff;
      hires_in    = hires_ff;
      mixed_in    = mixed_ff;
      page_in     = page_ff;
      ctrl_in     = ctrl_ff;
      latch_in    = latch_ff;
      last_key_in = last_key_ff;
      rd          = 8'h00;
      key         = req_key_code;

      // switch area flips on reads and writes alike
      sw_hit = (cmd == sskio_pkg::CMD_WRITE) ||
               ((cmd == sskio_pkg::CMD_READ) &&
                (req_io_addr inside {[sskio_pkg::ADDR_GR_SET:sskio_pkg::ADDR_HIRES_SET]}));

      // strobe clear on any access to the strobe address
      if ((cmd == sskio_pkg::CMD_READ || cmd == sskio_pkg::CMD_WRITE) &&
          req_io_addr == sskio_pkg::ADDR_STROBE) begin
         latch_in = latch_ff & sskio_pkg::STROBE_CLR;
      end

      if (sw_hit) begin
         case (req_io_addr)
            sskio_pkg::ADDR_GR_SET:    graphic_in = 1'b1;
            sskio_pkg::ADDR_GR_CLR:    graphic_in = 1'b0;
            sskio_pkg::ADDR_MIX_CLR:   mixed_in   = 1'b0;
            sskio_pkg::ADDR_MIX_SET:   mixed_in   = 1'b1;
            sskio_pkg::ADDR_PAGE_ONE:  page_in    = 1'b0;
            sskio_pkg::ADDR_PAGE_TWO:  page_in    = 1'b1;
            sskio_pkg::ADDR_HIRES_CLR: hires_in   = 1'b0;
            sskio_pkg::ADDR_HIRES_SET: hires_in   = 1'b1;
            default: ;
         endcase
      end

      case (cmd)
         sskio_pkg::CMD_READ: begin
            if (req_io_addr <= sskio_pkg::ADDR_LATCH_LAST ||
                req_io_addr == sskio_pkg::ADDR_STROBE) begin
               rd = latch_in[7:0];
            end else if (req_io_addr == sskio_pkg::ADDR_GR_STATUS) begin
               rd = graphic_ff ? 8'h00 : sskio_pkg::STATUS_ON;
            end else if (req_io_addr == sskio_pkg::ADDR_MIX_STATUS) begin
               rd = mixed_ff ? sskio_pkg::STATUS_ON : 8'h00;
            end else if (req_io_addr == sskio_pkg::ADDR_PAGE_STATUS) begin
               rd = page_ff ? sskio_pkg::STATUS_ON : 8'h00;
            end else if (req_io_addr == sskio_pkg::ADDR_HIRES_STATUS) begin
               rd = hires_ff ? sskio_pkg::STATUS_ON : 8'h00;
            end
         end
         sskio_pkg::CMD_WRITE: ;
         sskio_pkg::CMD_KEY: begin
            // priority: control toggle, break, enter, release, plain key
            if (req_key_code == ctrl_code_ff) begin
               ctrl_in = !ctrl_ff;
            end else begin
               if (req_key_code == break_code_ff) begin
                  ctrl_in  = 1'b1;
                  key      = sskio_pkg::KEY_CTRL_C;
                  latch_in = sskio_pkg::KEY_CTRL_C | sskio_pkg::STROBE_BIT;
               end else if (req_key_code == enter_code_ff) begin
                  key      = sskio_pkg::KEY_RETURN;
                  latch_in = sskio_pkg::KEY_RETURN | sskio_pkg::STROBE_BIT;
               end else if (req_key_code == sskio_pkg::KEY_RELEASED) begin
                  ctrl_in = 1'b0;
               end else begin
                  if (req_key_code >= sskio_pkg::KEY_LOWER_A &&
                      req_key_code <= sskio_pkg::KEY_LOWER_Z) begin
                     key = req_key_code & sskio_pkg::UPPER_MASK;
                  end
                  if (ctrl_ff) begin
                     if (key >= sskio_pkg::KEY_UPPER_A && key <= sskio_pkg::KEY_UPPER_Z) begin
                        key = key - sskio_pkg::CTRL_OFFSET;
                     end
                     ctrl_in = 1'b0;
                  end
                  latch_in = key | sskio_pkg::STROBE_BIT;
               end
               last_key_in = key;
            end
         end
         default: ;
      endcase

      // response from the flags after this beat
      rsp_in.read_data      = rd;
      rsp_in.graphic_on     = graphic_in;
      rsp_in.hires_on       = hires_in;
      rsp_in.mixed_on       = mixed_in;
      rsp_in.page_two       = page_in;
      rsp_in.translated_key = last_key_in;
      if (graphic_in && hires_in) begin
         if (mixed_in) begin
            rsp_in.window_begin = page_in ? sskio_pkg::TEXT2_BEGIN : sskio_pkg::TEXT1_BEGIN;
            rsp_in.window_end   = page_in ? sskio_pkg::MIXED2_END  : sskio_pkg::MIXED1_END;
         end else begin
            rsp_in.window_begin = page_in ? sskio_pkg::HIRES2_BEGIN : sskio_pkg::HIRES1_BEGIN;
            rsp_in.window_end   = page_in ? sskio_pkg::HIRES2_END   : sskio_pkg::HIRES1_END;
         end
      end else begin
         rsp_in.window_begin = page_in ? sskio_pkg::TEXT2_BEGIN : sskio_pkg::TEXT1_BEGIN;
         rsp_in.window_end   = page_in ? sskio_pkg::TEXT2_END   : sskio_pkg::TEXT1_END;
      end

      // output register: load on a taken request, drain on a taken response
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         graphic_ff   <= 1'b0;
         hires_ff     <= 1'b0;
         mixed_ff     <= 1'b0;
         page_ff      <= 1'b0;
         ctrl_ff      <= 1'b0;
         latch_ff     <= 16'h0000;
         last_key_ff  <= 16'h0000;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            graphic_ff  <= graphic_in;
            hires_ff    <= hires_in;
            mixed_ff    <= mixed_in;
            page_ff     <= page_in;
            ctrl_ff     <= ctrl_in;
            latch_ff    <= latch_in;
            last_key_ff <= last_key_in;
         end
      end
   end

   // response payload holds while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_ff.read_data;
   assign rsp_graphic_on     = rsp_ff.graphic_on;
   assign rsp_hires_on       = rsp_ff.hires_on;
   assign rsp_mixed_on       = rsp_ff.mixed_on;
   assign rsp_page_two       = rsp_ff.page_two;
   assign rsp_window_begin   = rsp_ff.window_begin;
   assign rsp_window_end     = rsp_ff.window_end;
   assign rsp_translated_key = rsp_ff.translated_key;

endmodule

### hdl/sskio_checker.sv
module sskio_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [1:0]  req_cmd,
   input logic [7:0]  req_io_addr,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_read_data,
   input logic        rsp_graphic_on,
   input logic        rsp_hires_on,
   input logic        rsp_mixed_on,
   input logic        rsp_page_two,
   input logic [15:0] rsp_window_begin
);

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // a stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   // every taken request shows a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("no response after a taken request");

   // a graphics-on switch access is reflected in its response
   a_gr_set: assert property (@(posedge clock) disable iff (reset)
      req_take && (req_cmd == sskio_pkg::CMD_WRITE || req_cmd == sskio_pkg::CMD_READ) &&
      req_io_addr == sskio_pkg::ADDR_GR_SET |=> rsp_graphic_on)
      else $error("graphics switch not applied");

   // window start agrees with the reported flags
   a_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(rsp_graphic_on && rsp_hires_on && !rsp_mixed_on) |->
      rsp_window_begin == (rsp_page_two ? sskio_pkg::TEXT2_BEGIN : sskio_pkg::TEXT1_BEGIN))
      else $error("window start does not match flags");

   // graphics status read reports the inverted flag
   a_gr_status: assert property (@(posedge clock) disable iff (reset)
      req_take && req_cmd == sskio_pkg::CMD_READ && req_io_addr == sskio_pkg::ADDR_GR_STATUS
      |=> rsp_read_data == (rsp_graphic_on ? 8'h00 : sskio_pkg::STATUS_ON))
      else $error("graphics status read wrong");

endmodule

bind soft_switch_keyboard_io_top sskio_checker u_sskio_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .req_io_addr      (req_io_addr),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_read_data    (rsp_read_data),
   .rsp_graphic_on   (rsp_graphic_on),
   .rsp_hires_on     (rsp_hires_on),
   .rsp_mixed_on     (rsp_mixed_on),
   .rsp_page_two     (rsp_page_two),
   .rsp_window_begin (rsp_window_begin)
);

### dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // codes that the package leaves without a name
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int BEATS_PER_PHASE = 75;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // request channel
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = sskio_pkg::CMD_READ;
   logic [7:0]  req_io_addr = 8'h00;
   logic [15:0] req_key_code = 16'h0000;

   // response channel
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_graphic_on;
   logic        rsp_hires_on;
   logic        rsp_mixed_on;
   logic        rsp_page_two;
   logic [15:0] rsp_window_begin;
   logic [15:0] rsp_window_end;
   logic [15:0] rsp_translated_key;

   // csr write channel
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = sskio_pkg::CSR_CTRL_KEY;
   logic [15:0] csr_data = 16'h0000;

   soft_switch_keyboard_io_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_io_addr        (req_io_addr),
      .req_key_code       (req_key_code),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_graphic_on     (rsp_graphic_on),
      .rsp_hires_on       (rsp_hires_on),
      .rsp_mixed_on       (rsp_mixed_on),
      .rsp_page_two       (rsp_page_two),
      .rsp_window_begin   (rsp_window_begin),
      .rsp_window_end     (rsp_window_end),
      .rsp_translated_key (rsp_translated_key),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // shadow copy of the i/o page: mode flags, keyboard latch, control toggle
   logic        vid_graphic, vid_hires, vid_mixed, vid_page;
   logic        ctrl_armed;
   logic [15:0] kbd_latch, last_key;
   // shadow copy of the key code registers
   logic [15:0] ctrl_code  = sskio_pkg::CTRL_KEY_RESET;
   logic [15:0] break_code = sskio_pkg::BREAK_KEY_RESET;
   logic [15:0] enter_code = sskio_pkg::ENTER_KEY_RESET;

   // responses still owed by the block, oldest first
   sskio_pkg::rsp_type pending_screens[$];
   sskio_pkg::rsp_type screen_want;

   // directed rows, walked in order after reset
   typedef struct {
      logic [1:0]         cmd;
      logic [7:0]         addr;
      logic [15:0]        code;
      bit                 typed;
      sskio_pkg::rsp_type want;
   } stim_row_type;
   stim_row_type directed_rows[$];

   // set near the end so the tail runs at full rate on both sides
   bit calm = 1'b0;
   int req_quiet = 0;
   int stall_left = 0;
   int stall_quiet = 0;

   int fail_count = 0;
   int beats_sent = 0;
   int rsp_checked = 0;
   int csr_writes = 0;
   int settings_seen = 1;

   // a soft switch touched by a read or a write, data bits ignored
   function automatic void flip_switch(input logic [7:0] addr);
      case (addr)
         sskio_pkg::ADDR_STROBE:    kbd_latch = kbd_latch & sskio_pkg::STROBE_CLR;
         sskio_pkg::ADDR_GR_SET:    vid_graphic = 1'b1;
         sskio_pkg::ADDR_GR_CLR:    vid_graphic = 1'b0;
         sskio_pkg::ADDR_MIX_CLR:   vid_mixed = 1'b0;
         sskio_pkg::ADDR_MIX_SET:   vid_mixed = 1'b1;
         sskio_pkg::ADDR_PAGE_ONE:  vid_page = 1'b0;
         sskio_pkg::ADDR_PAGE_TWO:  vid_page = 1'b1;
         sskio_pkg::ADDR_HIRES_CLR: vid_hires = 1'b0;
         sskio_pkg::ADDR_HIRES_SET: vid_hires = 1'b1;
         default: ;
      endcase
   endfunction

   // advances the shadow i/o page by one beat and returns the screen it reports
   function automatic sskio_pkg::rsp_type next_io_response(input logic [1:0] cmd,
                                                           input logic [7:0] addr,
                                                           input logic [15:0] code);
      sskio_pkg::rsp_type r;
      logic [15:0]        k;
      r = '0;
      k = code;
      case (cmd)
         sskio_pkg::CMD_READ: begin
            if (addr <= sskio_pkg::ADDR_LATCH_LAST) begin
               r.read_data = kbd_latch[7:0];
            end else if (addr == sskio_pkg::ADDR_STROBE) begin
               kbd_latch   = kbd_latch & sskio_pkg::STROBE_CLR;
               r.read_data = kbd_latch[7:0];
            end else if (addr == sskio_pkg::ADDR_GR_STATUS) begin
               // this one reports text mode, the others report set flags
               r.read_data = vid_graphic ? 8'h00 : sskio_pkg::STATUS_ON;
            end else if (addr == sskio_pkg::ADDR_MIX_STATUS) begin
               r.read_data = vid_mixed ? sskio_pkg::STATUS_ON : 8'h00;
            end else if (addr == sskio_pkg::ADDR_PAGE_STATUS) begin
               r.read_data = vid_page ? sskio_pkg::STATUS_ON : 8'h00;
            end else if (addr == sskio_pkg::ADDR_HIRES_STATUS) begin
               r.read_data = vid_hires ? sskio_pkg::STATUS_ON : 8'h00;
            end else if (addr >= sskio_pkg::ADDR_GR_SET &&
                         addr <= sskio_pkg::ADDR_HIRES_SET) begin
               flip_switch(addr);
            end
         end
         sskio_pkg::CMD_WRITE: flip_switch(addr);
         sskio_pkg::CMD_KEY: begin
            // first matching code wins: control, break, enter, release
            if (code == ctrl_code) begin
               ctrl_armed = ~ctrl_armed;
            end else begin
               if (code == break_code) begin
                  ctrl_armed = 1'b1;
                  k          = sskio_pkg::KEY_CTRL_C;
                  kbd_latch  = sskio_pkg::KEY_CTRL_C | sskio_pkg::STROBE_BIT;
               end else if (code == enter_code) begin
                  k         = sskio_pkg::KEY_RETURN;
                  kbd_latch = sskio_pkg::KEY_RETURN | sskio_pkg::STROBE_BIT;
               end else if (code == sskio_pkg::KEY_RELEASED) begin
                  ctrl_armed = 1'b0;
               end else begin
                  if (k >= sskio_pkg::KEY_LOWER_A && k <= sskio_pkg::KEY_LOWER_Z)
                     k = k & sskio_pkg::UPPER_MASK;
                  if (ctrl_armed) begin
                     if (k >= sskio_pkg::KEY_UPPER_A && k <= sskio_pkg::KEY_UPPER_Z)
                        k = k - sskio_pkg::CTRL_OFFSET;
                     ctrl_armed = 1'b0;
                  end
                  kbd_latch = k | sskio_pkg::STROBE_BIT;
               end
               last_key = k;
            end
         end
         default: ;
      endcase

      // video window follows the flags after the update
      if (vid_graphic && vid_hires) begin
         if (vid_mixed) begin
            r.window_begin = vid_page ? sskio_pkg::TEXT2_BEGIN : sskio_pkg::TEXT1_BEGIN;
            r.window_end   = vid_page ? sskio_pkg::MIXED2_END : sskio_pkg::MIXED1_END;
         end else begin
            r.window_begin = vid_page ? sskio_pkg::HIRES2_BEGIN : sskio_pkg::HIRES1_BEGIN;
            r.window_end   = vid_page ? sskio_pkg::HIRES2_END : sskio_pkg::HIRES1_END;
         end
      end else begin
         r.window_begin = vid_page ? sskio_pkg::TEXT2_BEGIN : sskio_pkg::TEXT1_BEGIN;
         r.window_end   = vid_page ? sskio_pkg::TEXT2_END : sskio_pkg::TEXT1_END;
      end
      r.graphic_on     = vid_graphic;
      r.hires_on       = vid_hires;
      r.mixed_on       = vid_mixed;
      r.page_two       = vid_page;
      r.translated_key = last_key;
      return r;
   endfunction

   task automatic add_row(input logic [1:0] cmd, input logic [7:0] addr,
                          input logic [15:0] code, input bit typed,
                          input sskio_pkg::rsp_type want);
      stim_row_type row;
      row.cmd   = cmd;
      row.addr  = addr;
      row.code  = code;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   // one request beat, at times with a random idle burst in front of it
   task automatic drive_beat(input logic [1:0] cmd, input logic [7:0] addr,
                             input logic [15:0] code, input bit typed,
                             input sskio_pkg::rsp_type want);
      int                 gap;
      sskio_pkg::rsp_type predicted;
      gap = 0;
      if (!calm) begin
         if (req_quiet > 0) begin
            req_quiet--;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: gap = $urandom_range(1, 11);
               3:       req_quiet = $urandom_range(20, 60);
               default: ;
            endcase
         end
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_io_addr  <= addr;
      req_key_code <= code;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      // beat taken at this edge; payload stays until the next beat replaces it
      predicted = next_io_response(cmd, addr, code);
      pending_screens.push_back(typed ? want : predicted);
      beats_sent++;
   endtask

   // holds csr_valid high, the caller lowers it after the last beat
   task automatic csr_beat(input logic [1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      case (idx)
         sskio_pkg::CSR_CTRL_KEY:  ctrl_code = val;
         sskio_pkg::CSR_BREAK_KEY: break_code = val;
         sskio_pkg::CSR_ENTER_KEY: enter_code = val;
         default: ;
      endcase
      csr_writes++;
   endtask

   // new key code setting, written only once the block has drained
   task automatic load_key_codes(input logic [15:0] ctrl_val,
                                 input logic [15:0] brk_val,
                                 input logic [15:0] enter_val,
                                 input bit poke_unused);
      req_valid <= 1'b0;
      while (pending_screens.size() != 0) @(posedge clock);
      // margin before the csr writes
      repeat (3) @(posedge clock);
      csr_beat(sskio_pkg::CSR_CTRL_KEY, ctrl_val);
      csr_beat(sskio_pkg::CSR_BREAK_KEY, brk_val);
      csr_beat(sskio_pkg::CSR_ENTER_KEY, enter_val);
      // unused index must leave every code alone
      if (poke_unused) csr_beat(CSR_UNUSED, 16'($urandom_range(0, 16'hFFFF)));
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_seen++;
   endtask

   // random traffic biased toward live addresses and the configured key codes
   task automatic run_random(input int count);
      logic [1:0]  cmd;
      logic [7:0]  addr;
      logic [15:0] code;
      int          pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 19);
         if (pick < 7) cmd = sskio_pkg::CMD_READ;
         else if (pick < 11) cmd = sskio_pkg::CMD_WRITE;
         else if (pick < 19) cmd = sskio_pkg::CMD_KEY;
         else cmd = CMD_UNUSED;

         case ($urandom_range(0, 5))
            0:       addr = 8'($urandom_range(0, sskio_pkg::ADDR_LATCH_LAST));
            1:       addr = sskio_pkg::ADDR_STROBE;
            2:       addr = 8'($urandom_range(sskio_pkg::ADDR_GR_STATUS,
                                              sskio_pkg::ADDR_HIRES_STATUS));
            3, 4:    addr = 8'($urandom_range(sskio_pkg::ADDR_GR_SET,
                                              sskio_pkg::ADDR_HIRES_SET));
            default: addr = 8'($urandom_range(0, 255));
         endcase

         code = 16'($urandom_range(0, 16'hFFFF));
         if (cmd == sskio_pkg::CMD_KEY) begin
            case ($urandom_range(0, 10))
               0: code = ctrl_code;
               1: code = break_code;
               2: code = enter_code;
               3: code = sskio_pkg::KEY_RELEASED;
               4, 5, 6: begin
                  code = 16'($urandom_range(0, 1) ?
                             $urandom_range(sskio_pkg::KEY_LOWER_A, sskio_pkg::KEY_LOWER_Z) :
                             $urandom_range(sskio_pkg::KEY_UPPER_A, sskio_pkg::KEY_UPPER_Z));
               end
               7: code = 16'($urandom_range(16'h0040, 16'h007F));
               8: begin
                  // control chord: toggle, then a letter
                  drive_beat(sskio_pkg::CMD_KEY, addr, ctrl_code, 1'b0, '0);
                  code = 16'($urandom_range(sskio_pkg::KEY_LOWER_A,
                                            sskio_pkg::KEY_LOWER_Z));
               end
               default: ;
            endcase
         end
         drive_beat(cmd, addr, code, 1'b0, '0);
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   // response side: random stall bursts and quiet stretches, none in the tail
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (stall_quiet > 0) begin
         stall_quiet = stall_quiet - 1;
         rsp_stall <= 1'b0;
      end else begin
         case ($urandom_range(0, 9))
            0, 1: begin
               stall_left = $urandom_range(1, 11) - 1;
               rsp_stall <= 1'b1;
            end
            2: begin
               stall_quiet = $urandom_range(20, 60);
               rsp_stall <= 1'b0;
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // every response beat is matched against the oldest owed screen
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_screens.size() == 0) begin
            $error("response beat with nothing expected");
            fail_count++;
         end else begin
            screen_want = pending_screens.pop_front();
            check_field("read_data", 16'(screen_want.read_data), 16'(rsp_read_data));
            check_field("graphic_on", 16'(screen_want.graphic_on), 16'(rsp_graphic_on));
            check_field("hires_on", 16'(screen_want.hires_on), 16'(rsp_hires_on));
            check_field("mixed_on", 16'(screen_want.mixed_on), 16'(rsp_mixed_on));
            check_field("page_two", 16'(screen_want.page_two), 16'(rsp_page_two));
            check_field("window_begin", screen_want.window_begin, rsp_window_begin);
            check_field("window_end", screen_want.window_end, rsp_window_end);
            check_field("translated_key", screen_want.translated_key,
                        rsp_translated_key);
            rsp_checked++;
         end
      end
   end

   initial begin
      vid_graphic = 1'b0;
      vid_hires   = 1'b0;
      vid_mixed   = 1'b0;
      vid_page    = 1'b0;
      ctrl_armed  = 1'b0;
      kbd_latch   = 16'h0000;
      last_key    = 16'h0000;

      // reset values and extremes, typed in: {g,h,m,p} then window
      add_row(sskio_pkg::CMD_READ, 8'h00, 16'hFFFF, 1'b1,
              {8'h00, 4'b0000, sskio_pkg::TEXT1_BEGIN, sskio_pkg::TEXT1_END, 16'h0000});
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_GR_STATUS, 16'h0000, 1'b1,
              {sskio_pkg::STATUS_ON, 4'b0000, sskio_pkg::TEXT1_BEGIN,
               sskio_pkg::TEXT1_END, 16'h0000});
      add_row(sskio_pkg::CMD_READ, 8'hFF, 16'hFFFF, 1'b1,
              {8'h00, 4'b0000, sskio_pkg::TEXT1_BEGIN, sskio_pkg::TEXT1_END, 16'h0000});
      // unused command touches nothing, even on a switch address
      add_row(CMD_UNUSED, sskio_pkg::ADDR_GR_SET, 16'hFFFF, 1'b1,
              {8'h00, 4'b0000, sskio_pkg::TEXT1_BEGIN, sskio_pkg::TEXT1_END, 16'h0000});
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_GR_SET, 16'h0000, 1'b1,
              {8'h00, 4'b1000, sskio_pkg::TEXT1_BEGIN, sskio_pkg::TEXT1_END, 16'h0000});
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_HIRES_SET, 16'h0000, 1'b1,
              {8'h00, 4'b1100, sskio_pkg::HIRES1_BEGIN, sskio_pkg::HIRES1_END,
               16'h0000});
      // a read of a switch flips it and returns zero
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_MIX_SET, 16'h0000, 1'b1,
              {8'h00, 4'b1110, sskio_pkg::TEXT1_BEGIN, sskio_pkg::MIXED1_END, 16'h0000});
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_PAGE_TWO, 16'h0000, 1'b1,
              {8'h00, 4'b1111, sskio_pkg::TEXT2_BEGIN, sskio_pkg::MIXED2_END, 16'h0000});
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_MIX_CLR, 16'h0000, 1'b1,
              {8'h00, 4'b1101, sskio_pkg::HIRES2_BEGIN, sskio_pkg::HIRES2_END,
               16'h0000});
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_HIRES_STATUS, 16'h0000, 1'b1,
              {sskio_pkg::STATUS_ON, 4'b1101, sskio_pkg::HIRES2_BEGIN,
               sskio_pkg::HIRES2_END, 16'h0000});
      // the rest goes through the shadow model
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_PAGE_STATUS, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_MIX_STATUS, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_GR_CLR, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_PAGE_ONE, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'h00, sskio_pkg::KEY_LOWER_A, 1'b0, '0);
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_LATCH_LAST, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_READ, sskio_pkg::ADDR_STROBE, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'hFF, sskio_pkg::CTRL_KEY_RESET, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'h00, sskio_pkg::KEY_LOWER_Z, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'h00, sskio_pkg::BREAK_KEY_RESET, 1'b0, '0);
      // control set by break, spent on a non-letter
      add_row(sskio_pkg::CMD_KEY, 8'h00, 16'h005B, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'h00, sskio_pkg::ENTER_KEY_RESET, 1'b0, '0);
      // release clears a pending control
      add_row(sskio_pkg::CMD_KEY, 8'h00, sskio_pkg::CTRL_KEY_RESET, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'h00, sskio_pkg::KEY_RELEASED, 1'b0, '0);
      add_row(sskio_pkg::CMD_KEY, 8'h00, 16'hFFFF, 1'b0, '0);
      add_row(sskio_pkg::CMD_WRITE, sskio_pkg::ADDR_STROBE, 16'h0000, 1'b0, '0);
      add_row(sskio_pkg::CMD_READ, 8'h00, 16'h0000, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         drive_beat(directed_rows[i].cmd, directed_rows[i].addr, directed_rows[i].code,
                    directed_rows[i].typed, directed_rows[i].want);
      run_random(BEATS_PER_PHASE);

      // extremes of the code range
      load_key_codes(16'h0000, 16'hFFFF, sskio_pkg::KEY_RETURN, 1'b0);
      run_random(BEATS_PER_PHASE);
      // break and enter equal, and break shadows key release
      load_key_codes(16'hFFFF, 16'h0000, 16'h0000, 1'b1);
      run_random(BEATS_PER_PHASE);
      // all three equal, on a letter
      load_key_codes(sskio_pkg::KEY_UPPER_A, sskio_pkg::KEY_UPPER_A,
                     sskio_pkg::KEY_UPPER_A, 1'b0);
      run_random(BEATS_PER_PHASE);
      // codes that shadow lower-case letters
      load_key_codes(sskio_pkg::KEY_LOWER_A, 16'h0063, sskio_pkg::KEY_LOWER_Z, 1'b0);
      run_random(BEATS_PER_PHASE);
      repeat (2) begin
         load_key_codes(16'($urandom_range(0, 16'hFFFF)),
                        16'($urandom_range(0, 16'hFFFF)),
                        16'($urandom_range(0, 16'hFFFF)), 1'b1);
         run_random(BEATS_PER_PHASE);
      end
      // back to reset codes, both sides at full rate
      load_key_codes(sskio_pkg::CTRL_KEY_RESET, sskio_pkg::BREAK_KEY_RESET,
                     sskio_pkg::ENTER_KEY_RESET, 1'b0);
      calm = 1'b1;
      run_random(BEATS_PER_PHASE);

      req_valid <= 1'b0;
      while (pending_screens.size() != 0) @(posedge clock);
      // any stray beat after the drain is caught by the checker
      repeat (5) @(posedge clock);

      $display("covered %0d request beats and %0d checked responses", beats_sent,
               rsp_checked);
      $display("across %0d key code settings with %0d csr beats", settings_seen,
               csr_writes);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $error("run timed out");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### files.f
hdl/sskio_pkg.sv
hdl/soft_switch_keyboard_io_top.sv
hdl/sskio_checker.sv
dv/testbench.sv
